// ----- design/mlpf_pkg.sv -----
package mlpf_pkg;

  // Data path widths
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ACC_W     = 56;
  localparam int unsigned CFG_W     = 5;
  localparam int unsigned WIDX_W    = 11;
  localparam int unsigned OIDX_W    = 4;
  localparam int unsigned NE_W      = 3;

  // Effective counts stay below 32, so six bits hold a count plus one
  localparam int unsigned CNT_W     = 6;
  localparam int unsigned PW        = 2 * CNT_W;
  localparam int unsigned TOT_W     = 16;
  localparam int unsigned LYR_W     = 4;
  localparam int unsigned OUT_LIMIT = 16;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_INPUT = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    STAT_OUTPUT  = 2'd0,
    STAT_WREAD   = 2'd1,
    STAT_CNT_ERR = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_INPUT_COUNT  = 2'd0,
    CFG_EXTRA_LAYERS = 2'd1,
    CFG_HIDDEN_WIDTH = 2'd2,
    CFG_OUTPUT_COUNT = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TOT_A,
    ST_TOT_B,
    ST_WOP,
    ST_RDATA,
    ST_ERR,
    ST_MAC,
    ST_DRAIN,
    ST_ORD,
    ST_OEMIT
  } state_e;

  // Control word for the shared multiply-accumulate unit
  typedef struct packed {
    logic clear;
    logic valid;
    logic bias;
  } mac_ctl_t;

endpackage

// ----- design/mlpf_ram.sv -----
module mlpf_ram #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Register the read word, hold it while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/mlpf_mac.sv -----
module mlpf_mac import mlpf_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mac_ctl_t                 ctl_i,
  input  logic signed [DATA_W-1:0] weight_i,
  input  logic signed [DATA_W-1:0] act_i,
  output logic                     busy_o,
  output logic signed [DATA_W-1:0] sum_o
);

  localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-DATA_W){1'b0}}, 32'h7FFF_FFFF};
  localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-DATA_W){1'b1}}, 32'h8000_0000};

  logic signed [2*DATA_W-1:0] mul;
  logic signed [2*DATA_W-1:0] neg_w;
  logic signed [2*DATA_W-1:0] prod_d, prod_q;
  logic signed [2*DATA_W-1:0] term;
  logic signed [ACC_W-1:0]    acc_d, acc_q;
  logic                       prod_valid_q;

  // Form the exact product; the bias term is -w placed above the fraction
  assign mul    = weight_i * act_i;
  assign neg_w  = -((2*DATA_W)'(weight_i));
  assign prod_d = ctl_i.bias ? (neg_w <<< 16) : mul;

  // Floor shift back to Q16.16 and accumulate
  assign term  = prod_q >>> 16;
  assign acc_d = acc_q + ACC_W'(term);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      acc_q        <= '0;
    end else begin
      prod_valid_q <= ctl_i.valid;
      if (ctl_i.clear) begin
        acc_q <= '0;
      end else if (prod_valid_q) begin
        acc_q <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.valid) begin
      prod_q <= prod_d;
    end
  end

  // Saturate the sum to 32 bits
  always_comb begin
    if (acc_q > SAT_HI) begin
      sum_o = SAT_HI[DATA_W-1:0];
    end else if (acc_q < SAT_LO) begin
      sum_o = SAT_LO[DATA_W-1:0];
    end else begin
      sum_o = acc_q[DATA_W-1:0];
    end
  end

  assign busy_o = prod_valid_q;

endmodule

// ----- design/mlp_linear_forward_pass_top.sv -----
// Linear multilayer perceptron: first hidden layer, extra hidden layers, output layer.
// Input channel (in_valid_i / in_ready_o) takes one word per handshake: a weight write,
// a weight read, or one element of the input vector with input_last_i on the final one.
// Output channel (out_valid_o / out_ready_i) carries weight read data, network outputs
// (one word per output neuron, out_last_o on the final one) or a single count error word.
// Configuration is written through cfg_we_i / cfg_index_i / cfg_data_i; the user must
// do so only while idle, as the block itself does not enforce it. The block takes one
// word at a time; in_ready_o is low while a word is worked on. An input element that is
// not last is taken in ST_IDLE; a weight write or read first passes through ST_TOT_A and
// ST_TOT_B, which form the total weight count, and then ST_WOP, and a read then puts its
// word on the output from ST_RDATA. A last element runs the whole pass on one shared
// multiply-accumulate unit: each neuron issues fan_in + 1 weight reads, one per cycle,
// then waits for the pipeline to drain; each output word is read and then emitted.
// Reset clears the configuration to one input, one hidden neuron, one output and no
// extra layers, and clears the element count; weights are undefined until written.
// A stalled receiver holds the output register and the sequencer waits on it; the
// next input word may be accepted while the last result still waits to be taken.
module mlp_linear_forward_pass_top import mlpf_pkg::*; #(
  parameter int unsigned MAX_INPUTS       = 16,
  parameter int unsigned MAX_WIDTH        = 16,
  parameter int unsigned MAX_EXTRA_LAYERS = 4,
  parameter int unsigned WEIGHT_DEPTH     = 2048
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               func_i,
  input  logic [WIDX_W-1:0]        weight_index_i,
  input  logic signed [DATA_W-1:0] data_value_i,
  input  logic                     input_last_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] out_value_o,
  output logic [OIDX_W-1:0]        out_index_o,
  output logic                     out_last_o,
  output logic [1:0]               out_status_o,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_index_i,
  input  logic [CFG_W-1:0]         cfg_data_i
);

  localparam int unsigned AW         = $clog2(WEIGHT_DEPTH);
  localparam int unsigned IDX_W      = (AW > TOT_W) ? AW : TOT_W;
  localparam int unsigned LC_W       = $clog2(MAX_INPUTS + 2);
  localparam int unsigned LAYER_BUF  = (MAX_WIDTH > OUT_LIMIT) ? MAX_WIDTH : OUT_LIMIT;
  localparam int unsigned AMEM_DEPTH = MAX_INPUTS + 2 * LAYER_BUF;
  localparam int unsigned AAW        = $clog2(AMEM_DEPTH);
  localparam logic [AAW-1:0] A_BASE  = AAW'(MAX_INPUTS);
  localparam logic [AAW-1:0] B_BASE  = AAW'(MAX_INPUTS + LAYER_BUF);
  localparam logic [IDX_W:0] WDEPTH  = (IDX_W+1)'(WEIGHT_DEPTH);

  state_e state_q, state_d;

  // Effective configuration
  logic [CNT_W-1:0] ni_q, nh_q, no_q;
  logic [NE_W-1:0]  ne_q;
  logic [CFG_W-1:0] cfg_v;
  logic [NE_W-1:0]  cfg_v3;

  // Word and pass state
  logic [LC_W-1:0]          lc_q, lc_d, lc_inc;
  logic [WIDX_W-1:0]        widx_q, widx_d;
  logic signed [DATA_W-1:0] data_q, data_d;
  logic                     rd_q, rd_d;
  logic                     rd_ok_q, rd_ok_d;
  logic [PW-1:0]            t1_q, t1_d, t2_q, t2_d, t3_q, t3_d;
  logic [TOT_W-1:0]         total_q, total_d;
  logic [LYR_W-1:0]         layer_q, layer_d;
  logic [CNT_W-1:0]         j_q, j_d, k_q, k_d;
  logic [IDX_W-1:0]         base_q, base_d;
  logic                     dst_sel_q, dst_sel_d;

  // Issue stage aligned with the memory read words
  logic iss_valid_q, iss_valid_d, iss_bias_q, iss_bias_d, iss_oob_q, iss_oob_d;

  // Pass helpers
  logic [CNT_W-1:0] fan, cnt;
  logic             last_layer;
  logic [AAW-1:0]   src_base, dst_base;
  logic [IDX_W-1:0] pass_idx, widx_ext;
  logic             widx_ok;

  // Memory ports
  logic                     wm_we, wm_re;
  logic [AW-1:0]            wm_waddr, wm_raddr;
  logic [DATA_W-1:0]        wm_rdata;
  logic                     am_we, am_re;
  logic [AAW-1:0]           am_waddr, am_raddr;
  logic [DATA_W-1:0]        am_wdata, am_rdata;

  // MAC unit
  mac_ctl_t                 mac_ctl;
  logic                     mac_clear, mac_busy;
  logic signed [DATA_W-1:0] mac_w, mac_sum;

  // Output register
  logic                     out_valid_q, out_free, out_load;
  logic signed [DATA_W-1:0] out_value_q, ov_d;
  logic [OIDX_W-1:0]        out_index_q, oi_d;
  logic                     out_last_q, ol_d;
  logic [1:0]               out_status_q;
  status_e                  os_d;

  // Clamp configuration words as they are written
  assign cfg_v  = cfg_data_i;
  assign cfg_v3 = cfg_data_i[NE_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ni_q <= CNT_W'(1);
      ne_q <= '0;
      nh_q <= CNT_W'(1);
      no_q <= CNT_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_INPUT_COUNT: begin
          ni_q <= (cfg_v == '0) ? CNT_W'(1) :
                  (int'(cfg_v) > MAX_INPUTS) ? CNT_W'(MAX_INPUTS) : CNT_W'(cfg_v);
        end
        CFG_EXTRA_LAYERS: begin
          ne_q <= (int'(cfg_v3) > MAX_EXTRA_LAYERS) ? NE_W'(MAX_EXTRA_LAYERS) : cfg_v3;
        end
        CFG_HIDDEN_WIDTH: begin
          nh_q <= (cfg_v == '0) ? CNT_W'(1) :
                  (int'(cfg_v) > MAX_WIDTH) ? CNT_W'(MAX_WIDTH) : CNT_W'(cfg_v);
        end
        CFG_OUTPUT_COUNT: begin
          no_q <= (cfg_v == '0) ? CNT_W'(1) :
                  (int'(cfg_v) > OUT_LIMIT) ? CNT_W'(OUT_LIMIT) : CNT_W'(cfg_v);
        end
        default: begin
        end
      endcase
    end
  end

  // Layer geometry and addresses
  assign last_layer = (layer_q == (LYR_W'(ne_q) + LYR_W'(1)));
  assign fan        = (layer_q == '0) ? ni_q : nh_q;
  assign cnt        = last_layer ? no_q : nh_q;
  assign dst_base   = dst_sel_q ? B_BASE : A_BASE;
  assign src_base   = (layer_q == '0) ? '0 : (dst_sel_q ? A_BASE : B_BASE);
  assign pass_idx   = base_q + IDX_W'(k_q);
  assign widx_ext   = IDX_W'(widx_q);
  assign widx_ok    = (widx_ext < IDX_W'(total_q)) && ({1'b0, widx_ext} < WDEPTH);
  assign lc_inc     = (int'(lc_q) < MAX_INPUTS + 1) ? lc_q + LC_W'(1) : lc_q;
  assign out_free   = !out_valid_q || out_ready_i;

  // Sequencer: next state and datapath controls
  always_comb begin
    state_d     = state_q;
    lc_d        = lc_q;
    widx_d      = widx_q;
    data_d      = data_q;
    rd_d        = rd_q;
    rd_ok_d     = rd_ok_q;
    t1_d        = t1_q;
    t2_d        = t2_q;
    t3_d        = t3_q;
    total_d     = total_q;
    layer_d     = layer_q;
    j_d         = j_q;
    k_d         = k_q;
    base_d      = base_q;
    dst_sel_d   = dst_sel_q;
    iss_valid_d = 1'b0;
    iss_bias_d  = 1'b0;
    iss_oob_d   = 1'b0;
    in_ready_o  = 1'b0;
    wm_we       = 1'b0;
    wm_re       = 1'b0;
    wm_waddr    = widx_ext[AW-1:0];
    wm_raddr    = widx_ext[AW-1:0];
    am_we       = 1'b0;
    am_re       = 1'b0;
    am_waddr    = AAW'(lc_q);
    am_wdata    = data_value_i;
    am_raddr    = src_base + AAW'(k_q);
    mac_clear   = 1'b0;
    out_load    = 1'b0;
    ov_d        = '0;
    oi_d        = '0;
    ol_d        = 1'b1;
    os_d        = STAT_OUTPUT;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (func_i)
            FUNC_WRITE, FUNC_READ: begin
              widx_d  = weight_index_i;
              data_d  = data_value_i;
              rd_d    = (func_i == FUNC_READ);
              state_d = ST_TOT_A;
            end
            FUNC_INPUT: begin
              // Store the element while there is room, count it regardless
              am_we = (int'(lc_q) < MAX_INPUTS);
              lc_d  = lc_inc;
              if (input_last_i) begin
                lc_d = '0;
                if (int'(lc_inc) != int'(ni_q)) begin
                  state_d = ST_ERR;
                end else begin
                  layer_d   = '0;
                  j_d       = '0;
                  k_d       = '0;
                  base_d    = '0;
                  dst_sel_d = 1'b0;
                  mac_clear = 1'b1;
                  state_d   = ST_MAC;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Total weight count, products first
      ST_TOT_A: begin
        t1_d    = PW'(nh_q) * PW'(ni_q + CNT_W'(1));
        t2_d    = PW'(nh_q) * PW'(nh_q + CNT_W'(1));
        t3_d    = PW'(no_q) * PW'(nh_q + CNT_W'(1));
        state_d = ST_TOT_B;
      end

      ST_TOT_B: begin
        total_d = TOT_W'(t1_q) + TOT_W'(ne_q) * TOT_W'(t2_q) + TOT_W'(t3_q);
        state_d = ST_WOP;
      end

      ST_WOP: begin
        if (rd_q) begin
          wm_re   = 1'b1;
          rd_ok_d = widx_ok;
          state_d = ST_RDATA;
        end else begin
          wm_we   = widx_ok;
          state_d = ST_IDLE;
        end
      end

      ST_RDATA: begin
        if (out_free) begin
          out_load = 1'b1;
          ov_d     = rd_ok_q ? wm_rdata : '0;
          os_d     = STAT_WREAD;
          state_d  = ST_IDLE;
        end
      end

      ST_ERR: begin
        if (out_free) begin
          out_load = 1'b1;
          os_d     = STAT_CNT_ERR;
          state_d  = ST_IDLE;
        end
      end

      // Issue one weight and one value per cycle; the bias weight comes last, with no value
      ST_MAC: begin
        wm_re       = 1'b1;
        wm_raddr    = pass_idx[AW-1:0];
        am_re       = (k_q != fan);
        iss_valid_d = 1'b1;
        iss_bias_d  = (k_q == fan);
        iss_oob_d   = ({1'b0, pass_idx} >= WDEPTH);
        if (k_q == fan) begin
          state_d = ST_DRAIN;
        end else begin
          k_d = k_q + CNT_W'(1);
        end
      end

      // Wait for the pipeline to empty, then store the neuron value
      ST_DRAIN: begin
        if (!iss_valid_q && !mac_busy) begin
          am_we     = 1'b1;
          am_waddr  = dst_base + AAW'(j_q);
          am_wdata  = mac_sum;
          base_d    = base_q + IDX_W'(fan) + IDX_W'(1);
          mac_clear = 1'b1;
          k_d       = '0;
          if (j_q + CNT_W'(1) == cnt) begin
            j_d = '0;
            if (last_layer) begin
              state_d = ST_ORD;
            end else begin
              layer_d   = layer_q + LYR_W'(1);
              dst_sel_d = !dst_sel_q;
              state_d   = ST_MAC;
            end
          end else begin
            j_d     = j_q + CNT_W'(1);
            state_d = ST_MAC;
          end
        end
      end

      ST_ORD: begin
        am_re    = 1'b1;
        am_raddr = dst_base + AAW'(j_q);
        state_d  = ST_OEMIT;
      end

      ST_OEMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          ov_d     = am_rdata;
          oi_d     = j_q[OIDX_W-1:0];
          ol_d     = (j_q + CNT_W'(1) == no_q);
          os_d     = STAT_OUTPUT;
          if (j_q + CNT_W'(1) == no_q) begin
            state_d = ST_IDLE;
          end else begin
            j_d     = j_q + CNT_W'(1);
            state_d = ST_ORD;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lc_q        <= '0;
      iss_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lc_q        <= lc_d;
      iss_valid_q <= iss_valid_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload and sequencer working registers
  always_ff @(posedge clk_i) begin
    widx_q    <= widx_d;
    data_q    <= data_d;
    rd_q      <= rd_d;
    rd_ok_q   <= rd_ok_d;
    t1_q      <= t1_d;
    t2_q      <= t2_d;
    t3_q      <= t3_d;
    total_q   <= total_d;
    layer_q   <= layer_d;
    j_q       <= j_d;
    k_q       <= k_d;
    base_q    <= base_d;
    dst_sel_q <= dst_sel_d;
    iss_bias_q <= iss_bias_d;
    iss_oob_q  <= iss_oob_d;
    if (out_load) begin
      out_value_q  <= ov_d;
      out_index_q  <= oi_d;
      out_last_q   <= ol_d;
      out_status_q <= os_d;
    end
  end

  // Weight store
  mlpf_ram #(
    .DEPTH (WEIGHT_DEPTH),
    .WIDTH (DATA_W)
  ) u_wmem (
    .clk_i   (clk_i),
    .we_i    (wm_we),
    .waddr_i (wm_waddr),
    .wdata_i (data_q),
    .re_i    (wm_re),
    .raddr_i (wm_raddr),
    .rdata_o (wm_rdata)
  );

  // Input vector and the two layer buffers
  mlpf_ram #(
    .DEPTH (AMEM_DEPTH),
    .WIDTH (DATA_W)
  ) u_amem (
    .clk_i   (clk_i),
    .we_i    (am_we),
    .waddr_i (am_waddr),
    .wdata_i (am_wdata),
    .re_i    (am_re),
    .raddr_i (am_raddr),
    .rdata_o (am_rdata)
  );

  // Shared multiply-accumulate unit; weights beyond the store count as zero
  assign mac_w         = iss_oob_q ? '0 : wm_rdata;
  assign mac_ctl.clear = mac_clear;
  assign mac_ctl.valid = iss_valid_q;
  assign mac_ctl.bias  = iss_bias_q;

  mlpf_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (mac_ctl),
    .weight_i (mac_w),
    .act_i    (am_rdata),
    .busy_o   (mac_busy),
    .sum_o    (mac_sum)
  );

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = out_value_q;
  assign out_index_o  = out_index_q;
  assign out_last_o   = out_last_q;
  assign out_status_o = out_status_q;

endmodule
